@@ rtl/periodic_task_timer_scheduler_top_defines.svh @@
// Assertion macros for the periodic task timer scheduler.
// Included by the top level; relies on signals named clk and rst in scope.
`ifndef PERIODIC_TASK_TIMER_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TASK_TIMER_SCHEDULER_TOP_DEFINES_SVH

// Checked only while reset is low.
`define PTTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PTTS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ptts_pkg.sv @@
// Shared types, codes and helpers for the periodic task timer scheduler.
// No dependencies; used by the result stage and the top level.
package ptts_pkg;

  localparam int MAX_FIRES = 16;
  localparam int FIRE_IW   = $clog2(MAX_FIRES);
  localparam int FIRE_CW   = $clog2(MAX_FIRES + 1);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_UNDEF  = 2'd3;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_ZERO_INTERVAL = 3'd1;
  localparam logic [2:0] ST_DUPLICATE     = 3'd2;
  localparam logic [2:0] ST_FULL          = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND     = 3'd4;

  typedef struct packed {
    logic [7:0]  key;
    logic [30:0] period;
    logic [31:0] deadline;
    logic [31:0] runs;
  } slot_t;

  // Requests from the sequencer to the result stage.
  typedef struct packed {
    logic       push;
    logic [7:0] fire_key;
    logic       fire_final;
    logic       start;
    logic [2:0] status;
    logic [4:0] count;
  } resp_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FIND_ORD,
    S_FIND_SLOT,
    S_FIND_CMP,
    S_ADD_WR,
    S_INS_ORD,
    S_INS_SLOT,
    S_INS_CMP,
    S_SHF_RD,
    S_SHF_WR,
    S_INS_DONE,
    S_DEL_RD,
    S_DEL_WR,
    S_DEL_DONE,
    S_TICK_ORD,
    S_TICK_SLOT,
    S_TICK_CMP,
    S_DONE,
    S_WAIT
  } state_t;

  // Wrap-safe ordering: a is earlier than b.
  function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

@@ rtl/ptts_in_if.sv @@
// Input channel of the periodic task timer scheduler: valid/ready plus command.
// Depends on nothing.
interface ptts_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [7:0]         task_id;
  logic [30:0]        period_ms;
  logic signed [31:0] repeat_count;
  logic [31:0]        now_ms;

  modport source (output valid, cmd, task_id, period_ms, repeat_count, now_ms,
                  input ready);
  modport sink (input valid, cmd, task_id, period_ms, repeat_count, now_ms,
                output ready);
endinterface

@@ rtl/ptts_out_if.sv @@
// Result channel of the periodic task timer scheduler: valid/ready plus result.
// Depends on nothing.
interface ptts_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] status;
  logic [7:0] fired_id;
  logic       final_run;
  logic [4:0] task_count;
  logic       last;

  modport source (output valid, kind, status, fired_id, final_run, task_count, last,
                  input ready);
  modport sink (input valid, kind, status, fired_id, final_run, task_count, last,
                output ready);
endinterface

@@ rtl/ptts_resp.sv @@
// Result stage: buffers the firings of a tick, then emits them with the final count.
// Depends on ptts_pkg and ptts_out_if.
module ptts_resp
  import ptts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  resp_ctl_t  ctl,
  output logic       busy,
  ptts_out_if.source out_ch
);

  logic [8:0]         fq_mem [MAX_FIRES];
  logic [8:0]         fq_rdata;
  logic [FIRE_CW-1:0] wr_cnt;
  logic [FIRE_CW-1:0] rd_idx;
  logic               emitting;
  logic               have;
  logic [2:0]         end_status;
  logic [4:0]         end_count;
  logic               o_valid;
  logic               ofree;
  logic               load_fire;
  logic               load_end;

  assign ofree     = !o_valid || out_ch.ready;
  assign load_fire = emitting && (rd_idx != wr_cnt) && have && ofree;
  assign load_end  = emitting && (rd_idx == wr_cnt) && ofree;
  assign busy      = emitting;
  assign out_ch.valid = o_valid;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      fq_mem[wr_cnt[FIRE_IW-1:0]] <= {ctl.fire_key, ctl.fire_final};
    end
    fq_rdata <= fq_mem[rd_idx[FIRE_IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_cnt   <= '0;
      rd_idx   <= '0;
      emitting <= 1'b0;
      have     <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (ctl.push) begin
        wr_cnt <= wr_cnt + FIRE_CW'(1);
      end
      if (ctl.start) begin
        emitting   <= 1'b1;
        rd_idx     <= '0;
        have       <= 1'b0;
        end_status <= ctl.status;
        end_count  <= ctl.count;
      end else if (load_fire) begin
        rd_idx <= rd_idx + FIRE_CW'(1);
        have   <= 1'b0;
      end else if (load_end) begin
        emitting <= 1'b0;
        wr_cnt   <= '0;
        have     <= 1'b0;
      end else begin
        // The read data is registered, so it is good in the cycle after the index settles.
        have <= emitting;
      end
      if (load_fire || load_end) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      out_ch.kind       <= 1'b1;
      out_ch.status     <= ST_OK;
      out_ch.fired_id   <= fq_rdata[8:1];
      out_ch.final_run  <= fq_rdata[0];
      out_ch.task_count <= end_count;
      out_ch.last       <= 1'b0;
    end else if (load_end) begin
      out_ch.kind       <= 1'b0;
      out_ch.status     <= end_status;
      out_ch.fired_id   <= 8'd0;
      out_ch.final_run  <= 1'b0;
      out_ch.task_count <= end_count;
      out_ch.last       <= 1'b1;
    end
  end

endmodule

@@ rtl/periodic_task_timer_scheduler_top.sv @@
// Periodic task timer scheduler: a deadline-ordered task list kept in two memories.
// An add or remove first searches the held tasks for the key; an add then places the
// new task in deadline order or a remove unlinks it, and then the result is sent.
// A tick handles each due task in turn (scan, unlink, reinsert unless it was the final
// run), at most 16 firings, then emits the results. Throughput: one transaction at a
// time. Reset empties the table and sets the task limit to 16.
`include "periodic_task_timer_scheduler_top_defines.svh"
module periodic_task_timer_scheduler_top
  import ptts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  ptts_in_if.sink    in_ch,
  ptts_out_if.source out_ch
);

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  // Memories: task slots and the deadline-ordered list of slot numbers.
  slot_t         slot_mem [MAX_TASKS];
  logic [SW-1:0] ord_mem  [MAX_TASKS];
  slot_t         slot_rdata;
  logic [SW-1:0] ord_rdata;

  logic [SW-1:0] slot_raddr, slot_waddr, ord_raddr, ord_waddr, ord_wdata;
  logic          slot_we, ord_we;
  slot_t         slot_wdata;

  state_t        state, state_next;
  logic [MAX_TASKS-1:0] slot_valid;
  logic [CW-1:0] valid_ones;
  logic [4:0]    limit;
  logic [1:0]    cmd_r;
  logic [7:0]    key_r;
  logic [30:0]   per_r;
  logic [31:0]   runs_r;
  logic [31:0]   now_r;
  logic [CW-1:0] n, n_next, p, p_next, i, i_next, ins_n, ins_n_next;
  logic [SW-1:0] cur_s, cur_s_next, ins_s, ins_s_next, free_s;
  logic [31:0]   ins_dl, ins_dl_next;
  logic [2:0]    status_r, status_next;
  logic [FIRE_CW-1:0] fires, fires_next;
  logic          fin, fin_next;
  logic [7:0]    cur_key, cur_key_next;
  logic          valid_set, valid_clr;
  logic          accept, full, busy;
  resp_ctl_t     ctl;
  slot_t         fired;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full = (LW'(n) >= LW'(limit)) || (LW'(n) >= LW'(MAX_TASKS));
  assign valid_ones  = CW'($countones(slot_valid));

  always_comb begin
    free_s = '0;
    for (int k = MAX_TASKS - 1; k >= 0; k--) begin
      if (!slot_valid[k]) begin
        free_s = SW'(k);
      end
    end
  end

  always_comb begin
    fired = slot_rdata;
    fired.deadline = now_r + {1'b0, slot_rdata.period};
    if (!slot_rdata.runs[31]) begin
      fired.runs = slot_rdata.runs - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    slot_rdata <= slot_mem[slot_raddr];
    ord_rdata  <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      n          <= '0;
      slot_valid <= '0;
      limit      <= 5'd16;
    end else begin
      state <= state_next;
      n     <= n_next;
      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end
      if (valid_set) begin
        slot_valid[free_s] <= 1'b1;
      end
      if (valid_clr) begin
        slot_valid[cur_s] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_ch.cmd;
      key_r  <= in_ch.task_id;
      per_r  <= in_ch.period_ms;
      runs_r <= in_ch.repeat_count;
      now_r  <= in_ch.now_ms;
    end
    p        <= p_next;
    i        <= i_next;
    ins_n    <= ins_n_next;
    cur_s    <= cur_s_next;
    ins_s    <= ins_s_next;
    ins_dl   <= ins_dl_next;
    status_r <= status_next;
    fires    <= fires_next;
    fin      <= fin_next;
    cur_key  <= cur_key_next;
  end

  always_comb begin
    state_next   = state;
    n_next       = n;
    p_next       = p;
    i_next       = i;
    ins_n_next   = ins_n;
    cur_s_next   = cur_s;
    ins_s_next   = ins_s;
    ins_dl_next  = ins_dl;
    status_next  = status_r;
    fires_next   = fires;
    fin_next     = fin;
    cur_key_next = cur_key;
    valid_set    = 1'b0;
    valid_clr    = 1'b0;
    slot_raddr   = '0;
    ord_raddr    = '0;
    slot_we      = 1'b0;
    slot_waddr   = cur_s;
    slot_wdata   = fired;
    ord_we       = 1'b0;
    ord_waddr    = i[SW-1:0];
    ord_wdata    = ord_rdata;
    ctl          = '0;
    ctl.status   = status_r;
    ctl.count    = 5'(n);
    ctl.fire_key = cur_key;
    ctl.fire_final = fin;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          status_next = ST_OK;
          p_next      = '0;
          fires_next  = '0;
          unique case (in_ch.cmd)
            CMD_ADD: begin
              if (in_ch.period_ms == 31'd0) begin
                status_next = ST_ZERO_INTERVAL;
                state_next  = S_DONE;
              end else begin
                state_next = S_FIND_ORD;
              end
            end
            CMD_REMOVE: state_next = S_FIND_ORD;
            CMD_TICK:   state_next = S_TICK_ORD;
            default:    state_next = S_DONE;
          endcase
        end
      end

      S_FIND_ORD: begin
        ord_raddr = p[SW-1:0];
        if (p >= n) begin
          if (cmd_r == CMD_REMOVE) begin
            status_next = ST_NOT_FOUND;
            state_next  = S_DONE;
          end else if (full) begin
            status_next = ST_FULL;
            state_next  = S_DONE;
          end else begin
            state_next = S_ADD_WR;
          end
        end else begin
          state_next = S_FIND_SLOT;
        end
      end

      S_FIND_SLOT: begin
        slot_raddr = ord_rdata;
        cur_s_next = ord_rdata;
        state_next = S_FIND_CMP;
      end

      S_FIND_CMP: begin
        if (slot_rdata.key == key_r) begin
          if (cmd_r == CMD_REMOVE) begin
            i_next     = p;
            state_next = S_DEL_RD;
          end else begin
            status_next = ST_DUPLICATE;
            state_next  = S_DONE;
          end
        end else begin
          p_next     = p + CW'(1);
          state_next = S_FIND_ORD;
        end
      end

      S_ADD_WR: begin
        slot_we          = 1'b1;
        slot_waddr       = free_s;
        slot_wdata.key   = key_r;
        slot_wdata.period = per_r;
        slot_wdata.deadline = now_r + {1'b0, per_r};
        slot_wdata.runs  = runs_r;
        valid_set        = 1'b1;
        ins_s_next       = free_s;
        ins_dl_next      = now_r + {1'b0, per_r};
        ins_n_next       = n;
        p_next           = '0;
        state_next       = S_INS_ORD;
      end

      S_INS_ORD: begin
        ord_raddr = p[SW-1:0];
        if (p == ins_n) begin
          i_next     = ins_n;
          state_next = S_SHF_RD;
        end else begin
          state_next = S_INS_SLOT;
        end
      end

      S_INS_SLOT: begin
        slot_raddr = ord_rdata;
        state_next = S_INS_CMP;
      end

      S_INS_CMP: begin
        // Place before the first entry that is strictly later.
        if (is_before(ins_dl, slot_rdata.deadline)) begin
          i_next     = ins_n;
          state_next = S_SHF_RD;
        end else begin
          p_next     = p + CW'(1);
          state_next = S_INS_ORD;
        end
      end

      S_SHF_RD: begin
        ord_raddr = SW'(i - CW'(1));
        if (i == p) begin
          ord_we     = 1'b1;
          ord_waddr  = p[SW-1:0];
          ord_wdata  = ins_s;
          state_next = S_INS_DONE;
        end else begin
          state_next = S_SHF_WR;
        end
      end

      S_SHF_WR: begin
        ord_we     = 1'b1;
        i_next     = i - CW'(1);
        state_next = S_SHF_RD;
      end

      S_INS_DONE: begin
        if (cmd_r == CMD_ADD) begin
          n_next     = n + CW'(1);
          state_next = S_DONE;
        end else begin
          ctl.push   = 1'b1;
          fires_next = fires + FIRE_CW'(1);
          p_next     = '0;
          state_next = (fires_next == FIRE_CW'(MAX_FIRES)) ? S_DONE : S_TICK_ORD;
        end
      end

      S_DEL_RD: begin
        ord_raddr = SW'(i + CW'(1));
        if ((i + CW'(1)) >= n) begin
          state_next = S_DEL_DONE;
        end else begin
          state_next = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        ord_we     = 1'b1;
        i_next     = i + CW'(1);
        state_next = S_DEL_RD;
      end

      S_DEL_DONE: begin
        if (cmd_r == CMD_REMOVE) begin
          valid_clr  = 1'b1;
          n_next     = n - CW'(1);
          state_next = S_DONE;
        end else if (fin) begin
          valid_clr  = 1'b1;
          n_next     = n - CW'(1);
          ctl.push   = 1'b1;
          fires_next = fires + FIRE_CW'(1);
          p_next     = '0;
          state_next = (fires_next == FIRE_CW'(MAX_FIRES)) ? S_DONE : S_TICK_ORD;
        end else begin
          ins_s_next = cur_s;
          ins_n_next = n - CW'(1);
          p_next     = '0;
          state_next = S_INS_ORD;
        end
      end

      S_TICK_ORD: begin
        ord_raddr = p[SW-1:0];
        state_next = (p >= n) ? S_DONE : S_TICK_SLOT;
      end

      S_TICK_SLOT: begin
        slot_raddr = ord_rdata;
        cur_s_next = ord_rdata;
        state_next = S_TICK_CMP;
      end

      S_TICK_CMP: begin
        if (slot_rdata.runs == 32'd0) begin
          // A task added with no runs stays listed but never fires.
          p_next     = p + CW'(1);
          state_next = S_TICK_ORD;
        end else if (is_before(now_r, slot_rdata.deadline)) begin
          state_next = S_DONE;
        end else begin
          slot_we      = 1'b1;
          ins_dl_next  = fired.deadline;
          cur_key_next = slot_rdata.key;
          fin_next     = !slot_rdata.runs[31] && (slot_rdata.runs == 32'd1);
          i_next       = p;
          state_next   = S_DEL_RD;
        end
      end

      S_DONE: begin
        ctl.start  = 1'b1;
        state_next = S_WAIT;
      end

      S_WAIT: begin
        if (!busy) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  ptts_resp u_resp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .busy   (busy),
    .out_ch (out_ch)
  );

  `PTTS_ASSERT(a_count_bound, (n <= CW'(MAX_TASKS)), "task count above capacity")
  `PTTS_ASSERT(a_count_matches_valid, (state == S_IDLE) |-> (valid_ones == n), "bad task count")
  `PTTS_ASSERT(a_fire_cap, (state != S_IDLE) |-> (fires <= FIRE_CW'(MAX_FIRES)), "firing cap exceeded")
  `PTTS_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> ((n == '0) && (slot_valid == '0)), "table not empty after reset")

endmodule
